@@ src/sqs_pkg.sv @@
// Shared types and constants for the shift queue with search.
// Field widths, command and status codes, the cell control group.
// No dependencies.
`default_nettype none

package sqs_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  // Per-cell control: load the incoming value, take the neighbor's word,
  // and whether the cell holds a live entry for the search.
  typedef struct packed {
    logic load;
    logic shift;
    logic in_range;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ src/sqs_if.sv @@
// Handshake channels of the shift queue: command, result and configuration.
// Depends on sqs_pkg for the field widths.
`default_nettype none

interface sqs_cmd_if import sqs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface sqs_res_if import sqs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STAT_W-1:0]         status;
  logic signed [VALUE_W-1:0] data;
  logic [POS_W-1:0]          position;
  logic [COUNT_W-1:0]        count;
  logic                      empty_flag;
  logic                      full_flag;

  modport source (output valid, output status, output data, output position,
                  output count, output empty_flag, output full_flag, input ready);
  modport sink   (input valid, input status, input data, input position,
                  input count, input empty_flag, input full_flag, output ready);
endinterface

interface sqs_cfg_if import sqs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/sqs_cell.sv @@
// One storage cell of the queue chain: holds one word, takes a new value or
// its neighbor's word, and compares its word against the search key.
// Depends on sqs_pkg.
`default_nettype none

module sqs_cell import sqs_pkg::*; (
  input  logic                      clk,
  input  cell_ctl_t                 ctl,
  input  logic signed [VALUE_W-1:0] din,
  input  logic signed [VALUE_W-1:0] next_word,
  input  logic signed [VALUE_W-1:0] key,
  output logic signed [VALUE_W-1:0] word,
  output logic                      hit
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word <= din;
    end else if (ctl.shift) begin
      word <= next_word;
    end
  end

  assign hit = ctl.in_range && (word == key);

endmodule

`default_nettype wire

@@ src/sqs_first_hit.sv @@
// Finds the lowest set bit of the registered hit vector and encodes its index.
// Depends on sqs_pkg for the default depth.
`default_nettype none

module sqs_first_hit import sqs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic [DEPTH-1:0] hits,
  output logic             found,
  output logic [IDX_W-1:0] index
);

  logic [DEPTH-1:0] lowest;

  // Isolate the lowest set bit, then OR the indexes of the one-hot vector.
  assign lowest = hits & (~hits + DEPTH'(1));
  assign found  = |hits;

  always_comb begin
    index = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (lowest[i]) begin
        index = index | IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/shift_queue_with_search.sv @@
// Shift queue with search: a chain of cells holds the queue head-first.
// A command's result passes through the stage 1 registers and then the output
//   registers before it is valid; result stalls hold it back.
// Throughput: one command per cycle unless results stall; compares run in every
//   cell at once, and the first-hit encode sits in the second pipeline stage.
// Reset clears the fill count and sets the capacity to 16; the stored words
//   are not cleared and hold garbage until written.
`default_nettype none

module shift_queue_with_search import sqs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  sqs_cmd_if.sink   cmd,
  sqs_res_if.source res,
  sqs_cfg_if.sink   cfg
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] fill, fill_next;

  logic [CMP_W-1:0] cap_wide, cap_eff, fill_wide, fill_next_wide;

  logic signed [VALUE_W-1:0] words [DEPTH];
  logic [DEPTH-1:0]          cell_hit;

  logic accept, out_free;
  logic do_enq, do_deq;
  logic [STAT_W-1:0]         st0;
  logic signed [VALUE_W-1:0] data0;
  logic                      search0;

  // Stage 1 registers
  logic                      s1_valid;
  logic [STAT_W-1:0]         s1_status;
  logic                      s1_search;
  logic signed [VALUE_W-1:0] s1_data;
  logic [CNT_W-1:0]          s1_count;
  logic                      s1_empty;
  logic                      s1_full;
  logic [DEPTH-1:0]          s1_hits;

  // Output registers
  logic                      r_valid;
  logic [STAT_W-1:0]         r_status;
  logic signed [VALUE_W-1:0] r_data;
  logic [POS_W-1:0]          r_position;
  logic [COUNT_W-1:0]        r_count;
  logic                      r_empty;
  logic                      r_full;

  logic             hit_found;
  logic [IDX_W-1:0] hit_index;

  assign out_free  = !r_valid || res.ready;
  assign cmd.ready = !s1_valid || out_free;
  assign accept    = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg.valid) begin
      capacity <= cfg.data;
    end
  end

  assign cap_wide  = CMP_W'(capacity);
  assign cap_eff   = (cap_wide > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_wide;
  assign fill_wide = CMP_W'(fill);

  always_comb begin
    do_enq    = 1'b0;
    do_deq    = 1'b0;
    st0       = ST_OK;
    data0     = '0;
    search0   = 1'b0;
    fill_next = fill;
    case (cmd.command)
      CMD_ENQUEUE: begin
        if (fill_wide >= cap_eff) begin
          st0 = ST_FULL;
        end else begin
          do_enq    = 1'b1;
          fill_next = fill + CNT_W'(1);
        end
      end
      CMD_DEQUEUE: begin
        if (fill == '0) begin
          st0 = ST_EMPTY;
        end else begin
          do_deq    = 1'b1;
          data0     = words[0];
          fill_next = fill - CNT_W'(1);
        end
      end
      CMD_PEEK: begin
        if (fill == '0) begin
          st0 = ST_EMPTY;
        end else begin
          data0 = words[0];
        end
      end
      CMD_CLEAR: begin
        fill_next = '0;
      end
      CMD_SEARCH: begin
        search0 = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign fill_next_wide = CMP_W'(fill_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  // Cell chain: each cell shifts toward the head on dequeue.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    logic signed [VALUE_W-1:0] nbr;

    assign ctl.load     = accept && do_enq && (fill == CNT_W'(i));
    assign ctl.shift    = accept && do_deq;
    assign ctl.in_range = CNT_W'(i) < fill;
    assign nbr          = (i == DEPTH - 1) ? words[i] : words[(i + 1) % DEPTH];

    sqs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .din       (cmd.value),
      .next_word (nbr),
      .key       (cmd.value),
      .word      (words[i]),
      .hit       (cell_hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= st0;
      s1_search <= search0;
      s1_data   <= data0;
      s1_count  <= fill_next;
      s1_empty  <= (fill_next == '0);
      s1_full   <= (fill_next_wide >= cap_eff);
      s1_hits   <= cell_hit;
    end
  end

  sqs_first_hit #(.DEPTH(DEPTH)) u_first_hit (
    .hits  (s1_hits),
    .found (hit_found),
    .index (hit_index)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (out_free) begin
      r_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      r_data  <= s1_data;
      r_count <= COUNT_W'(s1_count);
      r_empty <= s1_empty;
      r_full  <= s1_full;
      if (s1_search) begin
        r_status   <= hit_found ? ST_OK : ST_NOT_FOUND;
        r_position <= hit_found ? POS_W'(hit_index) : '0;
      end else begin
        r_status   <= s1_status;
        r_position <= '0;
      end
    end
  end

  assign res.valid      = r_valid;
  assign res.status     = r_status;
  assign res.data       = r_data;
  assign res.position   = r_position;
  assign res.count      = r_count;
  assign res.empty_flag = r_empty;
  assign res.full_flag  = r_full;

endmodule

`default_nettype wire

@@ src/sqs_checker.sv @@
// Port-level checks for the shift queue with search, bound to the top level.
// Depends on sqs_pkg and shift_queue_with_search.
`default_nettype none

module sqs_checker import sqs_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [STAT_W-1:0]         res_status,
  input logic signed [VALUE_W-1:0] res_data,
  input logic [POS_W-1:0]          res_position,
  input logic [COUNT_W-1:0]        res_count,
  input logic                      res_empty,
  input logic                      res_full
);

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == ST_FULL) |-> res_full)
    else $error("full status without full flag");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == ST_EMPTY) |-> res_empty && (res_data == '0))
    else $error("empty status with data or without empty flag");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_empty |-> (res_count == '0))
    else $error("empty flag with nonzero count");

  a_not_found: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == ST_NOT_FOUND) |-> (res_position == '0))
    else $error("not-found result with nonzero position");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_data)
      && $stable(res_position) && $stable(res_count))
    else $error("stalled result changed");

endmodule

bind shift_queue_with_search sqs_checker u_sqs_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_status   (res.status),
  .res_data     (res.data),
  .res_position (res.position),
  .res_count    (res.count),
  .res_empty    (res.empty_flag),
  .res_full     (res.full_flag)
);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking bench for shift_queue_with_search: random and directed commands,
// capacity rewrites, results compared field by field against a software queue.
// Depends on sqs_pkg and the channel interfaces in sqs_if.sv.
`default_nettype none

module tb import sqs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH      = DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 90;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 40;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] data;
    logic [POS_W-1:0]          position;
    logic [COUNT_W-1:0]        count;
    logic                      empty_flag;
    logic                      full_flag;
  } queue_result_t;

  // Software copy of the queue; predicts one result per accepted command.
  class queue_scoreboard;
    logic [VALUE_W-1:0] held[QDEPTH];
    int unsigned        fill;
    logic [CAP_W-1:0]   capacity;
    queue_result_t      awaited[$];
    int                 errors;

    function new();
      fill     = 0;
      capacity = CAP_RESET;
      errors   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Value currently held somewhere in the queue, for searches that hit; random when the queue is empty.
    function logic [VALUE_W-1:0] held_value();
      if (fill == 0) return $urandom;
      return held[$urandom_range(0, fill - 1)];
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val);
      int unsigned   lim;
      queue_result_t r;
      lim = (capacity > QDEPTH) ? QDEPTH : capacity;
      r = '0;
      case (cmd)
        CMD_ENQUEUE: begin
          if (fill >= lim) begin
            r.status = ST_FULL;
          end else begin
            held[fill] = val;
            fill++;
          end
        end
        CMD_DEQUEUE: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.data = held[0];
            for (int i = 1; i < fill; i++) held[i-1] = held[i];
            fill--;
          end
        end
        CMD_PEEK: begin
          if (fill == 0) r.status = ST_EMPTY;
          else r.data = held[0];
        end
        CMD_CLEAR: fill = 0;
        CMD_SEARCH: begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < fill; i++) begin
            if (held[i] == val) begin
              r.status   = ST_OK;
              r.position = POS_W'(i);
              break;
            end
          end
        end
        default: ;
      endcase
      r.count      = COUNT_W'(fill);
      r.empty_flag = (fill == 0);
      r.full_flag  = (fill >= lim);
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $error("%s: expected %0h, got %0h", name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t exp;
      if (awaited.size() == 0) begin
        $error("result transfer with no command outstanding");
        errors++;
        return;
      end
      exp = awaited.pop_front();
      compare_field("status", 32'(exp.status), 32'(got.status));
      compare_field("data", exp.data, got.data);
      compare_field("position", 32'(exp.position), 32'(got.position));
      compare_field("count", 32'(exp.count), 32'(got.count));
      compare_field("empty_flag", 32'(exp.empty_flag), 32'(got.empty_flag));
      compare_field("full_flag", 32'(exp.full_flag), 32'(got.full_flag));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic hold_req;
  logic calm;
  int   cycles;

  queue_scoreboard sb;

  sqs_cmd_if cmd_if ();
  sqs_res_if res_if ();
  sqs_cfg_if cfg_if ();

  shift_queue_with_search #(.DEPTH(QDEPTH)) i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Observe all three channels at the edge; values seen here are pre-edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_capacity(cfg_if.data);
      if (cmd_if.valid && cmd_if.ready) sb.note_command(cmd_if.command, cmd_if.value);
      if (res_if.valid && res_if.ready) begin
        sb.check_result('{res_if.status, res_if.data, res_if.position, res_if.count,
                          res_if.empty_flag, res_if.full_flag});
      end
    end
  end

  // Result side: random stalls, one long hold-off on request, none when calm.
  initial begin
    res_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !calm) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send_cmd(logic [CMD_W-1:0] c, logic [VALUE_W-1:0] v);
    if (!calm && $urandom_range(0, 5) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= c;
    cmd_if.value   <= v;
    do @(posedge clk); while (!cmd_if.ready);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write capacity only with the queue idle and nothing outstanding.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    cmd_if.valid <= 1'b0;
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= cap;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 7) - 4;
      5: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // mode 0 fills, 1 drains, 2 mixes
  task automatic random_cmd(int mode);
    int roll;
    int enq_w;
    int deq_w;
    roll  = $urandom_range(0, 99);
    enq_w = (mode == 0) ? 60 : (mode == 1) ? 25 : 40;
    deq_w = (mode == 1) ? 40 : 20;
    if (roll < enq_w) begin
      send_cmd(CMD_ENQUEUE, pick_value());
    end else if (roll < enq_w + deq_w) begin
      send_cmd(CMD_DEQUEUE, $urandom);
    end else if (roll < enq_w + deq_w + 8) begin
      send_cmd(CMD_PEEK, $urandom);
    end else if (roll < enq_w + deq_w + 10) begin
      send_cmd(CMD_CLEAR, $urandom);
    end else if (roll < 96) begin
      send_cmd(CMD_SEARCH, ($urandom_range(0, 3) != 0) ? sb.held_value() : pick_value());
    end else begin
      send_cmd(CMD_W'($urandom_range(5, 7)), $urandom);
    end
  endtask

  initial begin
    logic [CAP_W-1:0] caps[PHASES];
    sb             = new();
    clk            = 1'b0;
    rst            = 1'b1;
    cycles         = 0;
    hold_req       = 1'b0;
    calm           = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.command = CMD_ENQUEUE;
    cmd_if.value   = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = CAP_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty queue, extremes, first of duplicate matches, unused codes, clear.
    send_cmd(CMD_DEQUEUE, 32'h0);
    send_cmd(CMD_PEEK, 32'h0);
    send_cmd(CMD_SEARCH, 32'h0);
    send_cmd(CMD_ENQUEUE, 32'h8000_0000);
    send_cmd(CMD_ENQUEUE, 32'h7FFF_FFFF);
    send_cmd(CMD_ENQUEUE, 32'hFFFF_FFFF);
    send_cmd(CMD_ENQUEUE, 32'h7FFF_FFFF);
    send_cmd(CMD_SEARCH, 32'h7FFF_FFFF);
    send_cmd(CMD_SEARCH, 32'h1234_5678);
    send_cmd(CMD_PEEK, 32'h0);
    send_cmd(CMD_DEQUEUE, 32'h0);
    send_cmd(3'd5, 32'h0);
    send_cmd(3'd6, 32'h5555_5555);
    send_cmd(3'd7, 32'hFFFF_FFFF);
    send_cmd(CMD_CLEAR, 32'h0);
    send_cmd(CMD_PEEK, 32'h0);
    // Capacity of one, then drop to zero below the current count.
    write_capacity(5'd1);
    send_cmd(CMD_ENQUEUE, 32'd42);
    send_cmd(CMD_ENQUEUE, 32'd43);
    write_capacity(5'd0);
    send_cmd(CMD_ENQUEUE, 32'd7);
    send_cmd(CMD_PEEK, 32'h0);
    send_cmd(CMD_DEQUEUE, 32'h0);
    send_cmd(CMD_ENQUEUE, 32'd1);

    caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd5, 5'd0, 5'd16, 5'd2, 5'd0, 5'd31};
    caps[5] = CAP_W'($urandom_range(0, 31));
    caps[8] = CAP_W'($urandom_range(0, 31));
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(caps[p]);
      if (p == 1) hold_req = 1'b1;
      if (p == PHASES - 1) calm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_cmd((n < PHASE_ITEMS / 2) ? (p % 3) : 2);
      end
    end

    cmd_if.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
